// ----- rtl/core/ntpts_pkg.sv -----
package ntpts_pkg;

	localparam int DIVIDEND_W = 31;
	localparam int DIVISOR_W  = 28;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

	localparam logic [3:0] ADDR_CLOCK = 4'h0;
	localparam logic [3:0] ADDR_WHOLE = 4'h4;
	localparam logic [3:0] ADDR_DUTY  = 4'h8;

	localparam logic [26:0] CLOCK_RST = 27'd125000000;
	localparam logic [15:0] WHOLE_RST = 16'd2285;
	localparam logic [6:0]  DUTY_RST  = 7'd50;

	localparam logic [15:0] DIV16_MIN = 16'd16;

	// ceil(2^23/10), exact floor(x/10) for x below 2^22
	localparam logic [19:0] RECIP10    = 20'd838861;
	localparam int          RECIP10_SH = 23;
	// ceil(2^30/100), exact floor(x/100) for x below 14128181
	localparam logic [23:0] RECIP100    = 24'd10737419;
	localparam int          RECIP100_SH = 30;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
		logic [DIVISOR_W-1:0]  remainder;
	} div_rsp_t;

endpackage

// ----- rtl/core/ntpts_div.sv -----
module ntpts_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ntpts_pkg::div_req_t  req,
	output ntpts_pkg::div_rsp_t  rsp
);

	logic [ntpts_pkg::DIVIDEND_W-1:0] quo_q;
	logic [ntpts_pkg::DIVISOR_W-1:0]  rem_q;
	logic [ntpts_pkg::DIVISOR_W-1:0]  divisor_q;
	logic [ntpts_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                             done_q;

	logic [ntpts_pkg::DIVISOR_W:0]    shifted;
	logic [ntpts_pkg::DIVISOR_W:0]    diff;
	logic                             ge;

	// one restoring step per cycle
	assign shifted = {rem_q, quo_q[ntpts_pkg::DIVIDEND_W-1]};
	assign ge      = shifted >= {1'b0, divisor_q};
	assign diff    = shifted - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= ntpts_pkg::DIV_CNT_W'(ntpts_pkg::DIVIDEND_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - ntpts_pkg::DIV_CNT_W'(1);
			if (cnt_q == ntpts_pkg::DIV_CNT_W'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[ntpts_pkg::DIVIDEND_W-2:0], ge};
			rem_q <= ge ? diff[ntpts_pkg::DIVISOR_W-1:0] : shifted[ntpts_pkg::DIVISOR_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// ----- rtl/core/note_to_pwm_tone_setup.sv -----
// Divisions run on the shared 31-step restoring divider.
// A tone item runs four divisions plus the time, level and scale steps; a rest
// runs one division; a zero length code skips the duration division.
// Throughput: one item at a time; the next is taken the cycle after the result
// is in the output register.
// Reset: async active low, config to defaults, last duration cleared, no result.
module note_to_pwm_tone_setup (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // note_frequency[15:0], length_code[23:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,  // clkdiv_integer[11:0], clkdiv_fraction[15:12],
	                                   // wrap_count[31:16], level_count[47:32],
	                                   // sound_ms[64:48], silence_ms[78:65], zero[79]
	output logic [0:0]  m_axis_tuser,  // tone_valid[0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DUR   = 4'd1;
	localparam logic [3:0] ST_TIME  = 4'd2;
	localparam logic [3:0] ST_DIV16 = 4'd3;
	localparam logic [3:0] ST_CLK   = 4'd4;
	localparam logic [3:0] ST_WRAP  = 4'd5;
	localparam logic [3:0] ST_LVL   = 4'd6;
	localparam logic [3:0] ST_SCALE = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	logic [26:0] clock_q;
	logic [15:0] whole_q;
	logic [6:0]  duty_q;
	logic [16:0] last_q;

	logic [3:0]  state_q;
	logic        launched_q;
	logic [15:0] freq_q;
	logic [7:0]  code_q;
	logic [16:0] d_q;
	logic [16:0] sound_q;
	logic [13:0] silence_q;
	logic [15:0] div16_q;
	logic [26:0] t_q;
	logic [15:0] wrap_q;
	logic [22:0] prod_q;
	logic [15:0] level_q;

	logic        out_valid_q;
	logic [79:0] out_data_q;
	logic        out_tone_q;

	logic        cfg_wr;
	logic        in_acc;
	logic        out_free;
	logic [7:0]  mag;
	logic [15:0] quo16;
	logic [15:0] div16_raw;
	logic [22:0] product;
	logic [19:0] d_times9;
	logic [39:0] sound_full;
	logic [36:0] silence_full;
	logic [46:0] level_full;
	logic [16:0] level_scaled;

	ntpts_pkg::div_req_t req;
	ntpts_pkg::div_rsp_t rsp;

	ntpts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		prdata = '0;
		if (paddr == ntpts_pkg::ADDR_CLOCK) begin
			prdata = 32'(clock_q);
		end else if (paddr == ntpts_pkg::ADDR_WHOLE) begin
			prdata = 32'(whole_q);
		end else if (paddr == ntpts_pkg::ADDR_DUTY) begin
			prdata = 32'(duty_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= ntpts_pkg::CLOCK_RST;
			whole_q <= ntpts_pkg::WHOLE_RST;
			duty_q  <= ntpts_pkg::DUTY_RST;
		end else if (cfg_wr) begin
			if (paddr == ntpts_pkg::ADDR_CLOCK) begin
				clock_q <= pwdata[26:0];
			end
			if (paddr == ntpts_pkg::ADDR_WHOLE) begin
				whole_q <= pwdata[15:0];
			end
			if (paddr == ntpts_pkg::ADDR_DUTY) begin
				duty_q <= pwdata[6:0];
			end
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign mag       = code_q[7] ? 8'(~code_q + 8'd1) : code_q;
	assign quo16     = rsp.quotient[15:0];
	assign div16_raw = rsp.quotient[15:0] + 16'(rsp.remainder != '0);
	assign product   = 23'(wrap_q) * 23'(duty_q);
	assign d_times9  = {d_q, 3'b000} + 20'(d_q);

	// divisions by ten and by a hundred as reciprocal multiplies
	assign sound_full   = 40'(d_times9) * 40'(ntpts_pkg::RECIP10);
	assign silence_full = 37'(d_q) * 37'(ntpts_pkg::RECIP10);
	assign level_full   = 47'(prod_q) * 47'(ntpts_pkg::RECIP100);
	assign level_scaled = level_full[ntpts_pkg::RECIP100_SH +: 17];

	always_comb begin
		req          = '0;
		req.start    = !launched_q;
		unique case (state_q)
			ST_DUR: begin
				req.dividend = ntpts_pkg::DIVIDEND_W'(whole_q);
				req.divisor  = ntpts_pkg::DIVISOR_W'(mag);
			end
			ST_DIV16: begin
				req.dividend = ntpts_pkg::DIVIDEND_W'(clock_q);
				req.divisor  = ntpts_pkg::DIVISOR_W'({freq_q, 12'd0});
			end
			ST_CLK: begin
				req.dividend = {clock_q, 4'd0};
				req.divisor  = ntpts_pkg::DIVISOR_W'(div16_q);
			end
			ST_WRAP: begin
				req.dividend = ntpts_pkg::DIVIDEND_W'(t_q);
				req.divisor  = ntpts_pkg::DIVISOR_W'(freq_q);
			end
			default: begin
				req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			launched_q  <= 1'b0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (req.start) begin
				launched_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= (s_axis_tdata[23:16] == 8'd0) ? ST_TIME : ST_DUR;
					end
				end
				ST_DUR: begin
					if (launched_q && rsp.done) begin
						launched_q <= 1'b0;
						state_q    <= ST_TIME;
						last_q     <= code_q[7] ? 17'(quo16) + 17'(quo16[15:1]) : 17'(quo16);
					end
				end
				ST_TIME: begin
					state_q <= (freq_q == 16'd0) ? ST_OUT : ST_DIV16;
				end
				ST_DIV16: begin
					if (launched_q && rsp.done) begin
						launched_q <= 1'b0;
						state_q    <= ST_CLK;
					end
				end
				ST_CLK: begin
					if (launched_q && rsp.done) begin
						launched_q <= 1'b0;
						state_q    <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					if (launched_q && rsp.done) begin
						launched_q <= 1'b0;
						state_q    <= ST_LVL;
					end
				end
				ST_LVL: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			freq_q <= s_axis_tdata[15:0];
			code_q <= s_axis_tdata[23:16];
			d_q    <= last_q;
		end
		if (state_q == ST_DUR && launched_q && rsp.done) begin
			d_q <= code_q[7] ? 17'(quo16) + 17'(quo16[15:1]) : 17'(quo16);
		end
		if (state_q == ST_TIME) begin
			sound_q   <= sound_full[ntpts_pkg::RECIP10_SH +: 17];
			silence_q <= silence_full[ntpts_pkg::RECIP10_SH +: 14];
		end
		if (state_q == ST_DIV16 && launched_q && rsp.done) begin
			div16_q <= (div16_raw < ntpts_pkg::DIV16_MIN) ? ntpts_pkg::DIV16_MIN : div16_raw;
		end
		if (state_q == ST_CLK && launched_q && rsp.done) begin
			t_q <= rsp.quotient[26:0];
		end
		if (state_q == ST_WRAP && launched_q && rsp.done) begin
			if (rsp.quotient == '0) begin
				wrap_q <= '0;
			end else if (rsp.quotient > ntpts_pkg::DIVIDEND_W'(65536)) begin
				wrap_q <= 16'hFFFF;
			end else begin
				wrap_q <= 16'(rsp.quotient - ntpts_pkg::DIVIDEND_W'(1));
			end
		end
		if (state_q == ST_LVL) begin
			prod_q <= product;
		end
		if (state_q == ST_SCALE) begin
			level_q <= (level_scaled > 17'd65535) ? 16'hFFFF : level_scaled[15:0];
		end
		if (state_q == ST_OUT && out_free) begin
			out_tone_q <= (freq_q != 16'd0);
			if (freq_q != 16'd0) begin
				out_data_q <= {1'b0, silence_q, sound_q, level_q, wrap_q,
					div16_q[3:0], div16_q[15:4]};
			end else begin
				out_data_q <= {1'b0, silence_q, sound_q, 48'd0};
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_tone_q;

endmodule

// ----- rtl/core/ntpts_chk.sv -----
module ntpts_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [79:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	// one item in flight: no second accept right behind the first
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken twice in a row");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled result changed");

	// rest carries zero PWM settings
	a_rest_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[47:0] == 48'd0)
		else $error("rest with nonzero PWM settings");

	// divider is clamped to at least 16 sixteenths
	a_div_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[11:0] != 12'd0)
		else $error("clock divider below one");

endmodule

bind note_to_pwm_tone_setup ntpts_chk u_ntpts_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ----- tb/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int SETTLE      = 250;

	typedef struct packed {
		logic        tone;
		logic [11:0] dint;
		logic [3:0]  dfrac;
		logic [15:0] wrap;
		logic [15:0] level;
		logic [16:0] sound;
		logic [13:0] silence;
	} tone_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;     // note_frequency[15:0], length_code[23:16]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;          // clkdiv_integer, clkdiv_fraction, wrap_count,
	                               // level_count, sound_ms, silence_ms, zero
	logic [0:0]  m_tuser;          // tone_valid
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// shadow config and state
	logic [26:0] cfg_clock = ntpts_pkg::CLOCK_RST;
	logic [15:0] cfg_whole = ntpts_pkg::WHOLE_RST;
	logic [6:0]  cfg_duty  = ntpts_pkg::DUTY_RST;
	logic [16:0] last_dur  = '0;

	logic [23:0] note_q[$];
	tone_t       tone_q[$];
	tone_t       want;
	logic        idle_en = 1'b1;
	int          src_gap;
	int          snk_left;
	logic        hold_done;
	int          n_results;
	int          n_err = 0;
	int          cyc = 0;

	note_to_pwm_tone_setup u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic tone_t tone_setup(logic [15:0] freq, logic [7:0] code);
		tone_t r;
		longint unsigned d, q, mag, den, div16, quo, wrap, level, clkhz;
		r = '0;
		if (code == 8'd0) begin
			d = last_dur;
		end else if (code[7]) begin
			mag = 256 - code;
			q = cfg_whole / mag;
			d = q + q / 2;
		end else begin
			d = cfg_whole / code;
		end
		d = d & 17'h1FFFF;
		last_dur = d[16:0];
		if (freq != 16'd0) begin
			clkhz = cfg_clock;
			den = longint'(freq) * 4096;
			div16 = clkhz / den + ((clkhz % den) != 0 ? 1 : 0);
			if (div16 < 16)
				div16 = 16;
			quo = (clkhz * 16 / div16) / freq;
			if (quo == 0)
				wrap = 0;
			else if (quo - 1 > 16'hFFFF)
				wrap = 16'hFFFF;
			else
				wrap = quo - 1;
			level = wrap * cfg_duty / 100;
			if (level > 16'hFFFF)
				level = 16'hFFFF;
			r.tone  = 1'b1;
			r.dint  = div16[15:4];
			r.dfrac = div16[3:0];
			r.wrap  = wrap[15:0];
			r.level = level[15:0];
		end
		r.sound   = 17'((d * 9) / 10);
		r.silence = 14'(d / 10);
		return r;
	endfunction

	function automatic void compare(string what, longint unsigned exp_v, longint unsigned got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
			n_err++;
		end
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			src_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (src_gap != 0) begin
				src_gap <= src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (note_q.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= note_q.pop_front();
				if (idle_en && $urandom_range(0, 5) == 0)
					src_gap <= $urandom_range(1, 8);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result sink, with one long hold-off to back up the block
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_left <= 0;
			hold_done <= 1'b0;
		end else if (snk_left != 0) begin
			snk_left <= snk_left - 1;
			m_tready <= 1'b0;
		end else if (!hold_done && n_results >= 200) begin
			hold_done <= 1'b1;
			snk_left <= 3000;
			m_tready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			snk_left <= $urandom_range(0, 7);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor and scoreboard
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_results <= 0;
		end else begin
			if (s_tvalid && s_tready)
				tone_q.push_back(tone_setup(s_tdata[15:0], s_tdata[23:16]));
			if (m_tvalid && m_tready) begin
				n_results <= n_results + 1;
				if (tone_q.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual %h_%h",
						$time, m_tuser, m_tdata);
					n_err++;
				end else begin
					want = tone_q.pop_front();
					compare("tone_valid", want.tone, m_tuser[0]);
					compare("clkdiv_integer", want.dint, m_tdata[11:0]);
					compare("clkdiv_fraction", want.dfrac, m_tdata[15:12]);
					compare("wrap_count", want.wrap, m_tdata[31:16]);
					compare("level_count", want.level, m_tdata[47:32]);
					compare("sound_ms", want.sound, m_tdata[64:48]);
					compare("silence_ms", want.silence, m_tdata[78:65]);
				end
			end
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cyc);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(input logic [26:0] clock_hz, input logic [15:0] whole,
			input logic [6:0] duty);
		apb_write(ntpts_pkg::ADDR_CLOCK, 32'(clock_hz));
		apb_write(ntpts_pkg::ADDR_WHOLE, 32'(whole));
		apb_write(ntpts_pkg::ADDR_DUTY, 32'(duty));
		cfg_clock = clock_hz;
		cfg_whole = whole;
		cfg_duty  = duty;
	endtask

	task automatic wait_drain();
		while (note_q.size() != 0 || s_tvalid || tone_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic push_note(input logic [15:0] freq, input logic [7:0] code);
		note_q.push_back({code, freq});
	endtask

	task automatic push_random(input int count);
		logic [15:0] freq;
		logic [7:0]  code;
		logic [7:0]  mag;
		repeat (count) begin
			case ($urandom_range(0, 9))
				0:       freq = 16'd0;
				1, 2, 3, 4, 5: freq = 16'($urandom_range(20, 5000));
				6:       freq = 16'($urandom_range(1, 19));
				default: freq = 16'($urandom);
			endcase
			case ($urandom_range(0, 3))
				0: code = 8'($urandom);
				1: code = 8'd0;
				default: begin
					mag = 8'd1 << $urandom_range(0, 5);
					code = $urandom_range(0, 1) ? -mag : mag;
				end
			endcase
			push_note(freq, code);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reuse before any duration, rests, field extremes, small divider
		push_note(16'd440, 8'd0);
		push_note(16'd0, 8'd4);
		push_note(16'd0, 8'd0);
		push_note(16'd1, 8'd1);
		push_note(16'd65535, 8'h80);
		push_note(16'd65535, 8'd127);
		push_note(16'd1, 8'hFF);
		push_note(16'd440, 8'd0);
		push_note(16'd523, 8'hF8);
		push_note(16'd30517, 8'd2);
		push_note(16'd30518, 8'd8);
		push_note(16'd2, 8'd16);
		push_note(16'd0, 8'hFC);
		push_note(16'd262, 8'd0);
		push_note(16'hAAAA, 8'h55);
		push_note(16'h5555, 8'hAA);
		push_note(16'd1907, 8'd1);
		push_note(16'd20, 8'hC0);
		push_note(16'd5000, 8'd32);
		push_note(16'd0, 8'd127);
		wait_drain();

		push_random(400);
		wait_drain();

		// zero clock and zero whole note, duty above the percent range
		set_config(27'd0, 16'd0, 7'd127);
		push_note(16'd440, 8'd4);
		push_note(16'd1, 8'd0);
		push_note(16'd65535, 8'h80);
		push_random(60);
		wait_drain();

		set_config(27'd1, 16'd1, 7'd0);
		push_random(80);
		wait_drain();

		set_config(27'h7FFFFFF, 16'hFFFF, 7'd100);
		push_note(16'd1, 8'hFF);
		push_note(16'd65535, 8'd1);
		push_random(200);
		wait_drain();

		set_config(27'($urandom_range(1, 27'h7FFFFFF)), 16'($urandom_range(1, 65535)),
			7'($urandom_range(0, 100)));
		push_random(200);
		wait_drain();

		set_config(27'd12000000, 16'd4000, 7'd25);
		push_random(100);
		wait_drain();
		idle_en = 1'b0;
		push_random(150);
		wait_drain();

		if (tone_q.size() != 0) begin
			$display("%0t: %0d results missing", $time, tone_q.size());
			n_err++;
		end
		if (n_err == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
